>>> src/cof_pkg.sv
// shared types and constants for the cell outflow pipeline
// used by every module under src; no dependencies
`default_nettype none

package cof_pkg;

	localparam int VALUE_W = 32;                  // field and saturation width
	localparam int FRAC_W  = 16;                  // fraction bits of the flow scale
	localparam int NLVL    = 5;                   // center plus four neighbours
	localparam int NROUND  = 6;                   // elimination rounds, the last one is settled
	localparam int LW      = VALUE_W + 1;         // level and mass width
	localparam int SW      = VALUE_W + 4;         // sum of mass and five levels
	localparam int PW      = SW + 2;              // compare width for level times count
	localparam int CNT_W   = 3;
	localparam int RATE_W  = 17;
	localparam int EPS_W   = 16;
	localparam int IN_W    = 2 * NLVL * VALUE_W;
	localparam int OUT_W   = (NLVL - 1) * VALUE_W;
	localparam int CFG_AW  = 1;

	localparam logic [RATE_W-1:0] RATE_ONE   = RATE_W'(65536);
	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(32768);
	localparam logic [EPS_W-1:0]  EPS_RESET  = EPS_W'(66);

	typedef enum logic [CFG_AW-1:0] {
		REG_RATE = 1'b0,
		REG_EPS  = 1'b1
	} cfg_reg_t;

	// item state between elimination rounds
	typedef struct packed {
		logic [NLVL-1:0]         gone;
		logic [CNT_W-1:0]        cnt;
		logic [SW-1:0]           sum;
		logic [LW-1:0]           mass;
		logic [NLVL-1:0][LW-1:0] lvl;
	} round_t;

	// item state after the average is known
	typedef struct packed {
		logic [NLVL-1:0]         gone;
		logic [NLVL-1:0][LW-1:0] lvl;
		logic [SW-1:0]           avg;
	} avg_t;

endpackage

`default_nettype wire

>>> src/cell_outflow_minimization.sv
// pipeline: 20 register stages (1 entry, 12 for six rounds of two, 4 divide, 3 flow)
// throughput: one cell per cycle; the whole pipeline advances whenever the output
// register is empty or taken, so s_tready falls only while a result waits on m_tready
// reset: arst_n clears all valid bits and loads relaxation_rate 32768, epsilon_level 66
// depends on cof_pkg, cof_round, cof_div, cof_flow
`default_nettype none

module cell_outflow_minimization import cof_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// center_altitude, center_depth, north_altitude, north_depth, west_altitude,
	// west_depth, east_altitude, east_depth, south_altitude, south_depth
	input  logic [IN_W-1:0]   s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// flow_north, flow_west, flow_east, flow_south
	output logic [OUT_W-1:0]  m_tdata,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [RATE_W-1:0] cfg_wdata
);

	logic              en;
	logic [RATE_W-1:0] rate_q, rate_c;
	logic [EPS_W-1:0]  eps_q;
	round_t            entry_c;
	logic              rnd_v [NROUND+1];
	round_t            rnd   [NROUND+1];
	logic              div_v;
	avg_t              div_a;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
			eps_q  <= EPS_RESET;
		end else if (cfg_we) begin
			if (cfg_addr == REG_RATE)
				rate_q <= cfg_wdata;
			else
				eps_q <= cfg_wdata[EPS_W-1:0];
		end
	end

	assign rate_c = (rate_q > RATE_ONE) ? RATE_ONE : rate_q;

	always_comb begin
		entry_c.gone   = '0;
		entry_c.cnt    = '0;
		entry_c.sum    = '0;
		entry_c.mass   = LW'($signed(s_tdata[VALUE_W +: VALUE_W])) - LW'(eps_q);
		entry_c.lvl[0] = LW'($signed(s_tdata[0 +: VALUE_W])) + LW'(eps_q);
		for (int n = 1; n < NLVL; n++)
			entry_c.lvl[n] = LW'($signed(s_tdata[2*n*VALUE_W +: VALUE_W]))
				+ LW'($signed(s_tdata[(2*n+1)*VALUE_W +: VALUE_W]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rnd_v[0] <= 1'b0;
		else if (en)
			rnd_v[0] <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en)
			rnd[0] <= entry_c;
	end

	for (genvar r = 0; r < NROUND; r++) begin : g_round
		cof_round u_round (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vin    (rnd_v[r]),
			.rin    (rnd[r]),
			.vout   (rnd_v[r+1]),
			.rout   (rnd[r+1])
		);
	end

	cof_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (rnd_v[NROUND]),
		.rin    (rnd[NROUND]),
		.vout   (div_v),
		.aout   (div_a)
	);

	cof_flow u_flow (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (div_v),
		.ain    (div_a),
		.rate   (rate_c),
		.vout   (m_tvalid),
		.flows  (m_tdata)
	);

	// flows are never negative
	a_flow_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[VALUE_W-1] || m_tdata[2*VALUE_W-1]
			|| m_tdata[3*VALUE_W-1] || m_tdata[4*VALUE_W-1]))
		else $error("negative outflow");

	// final count matches the surviving levels
	a_cnt_gone: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_v[NROUND] |-> rnd[NROUND].cnt == CNT_W'(NLVL - $countones(rnd[NROUND].gone)))
		else $error("live count out of step with elimination bits");

	// the pipeline only stalls behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("stall without output backpressure");

	// nothing comes out right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid out of reset");

endmodule

`default_nettype wire

>>> src/cof_round.sv
// one elimination round: sum of mass and live levels, then compare each level with the average
// depends on cof_pkg
`default_nettype none

module cof_round import cof_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   vin,
	input  round_t rin,
	output logic   vout,
	output round_t rout
);

	logic            v_s1, v_s2;
	round_t          r_s1, r_s2;
	round_t          r1_c, r2_c;
	logic signed [SW-1:0] sum_c;
	logic [CNT_W-1:0]     cnt_c;
	logic signed [PW-1:0] sum_x, cnt_x;
	logic signed [PW-1:0] lc_c  [NLVL];
	logic signed [PW-1:0] thr_c [NLVL];
	logic [NLVL-1:0]      elim_c;

	always_comb begin
		sum_c = SW'($signed(rin.mass));
		cnt_c = '0;
		for (int n = 0; n < NLVL; n++) begin
			if (!rin.gone[n]) begin
				sum_c = sum_c + SW'($signed(rin.lvl[n]));
				cnt_c = cnt_c + CNT_W'(1);
			end
		end
		r1_c     = rin;
		r1_c.sum = sum_c;
		r1_c.cnt = cnt_c;
	end

	// trunc(sum/cnt) <= lvl without dividing:
	// sum >= 0 : sum <= lvl*cnt + cnt - 1, sum < 0 : sum <= lvl*cnt
	always_comb begin
		sum_x = PW'($signed(r_s1.sum));
		cnt_x = PW'(r_s1.cnt);
		for (int n = 0; n < NLVL; n++) begin
			lc_c[n]  = PW'($signed(r_s1.lvl[n])) * cnt_x;
			thr_c[n] = sum_x[PW-1] ? lc_c[n] : lc_c[n] + cnt_x - PW'(1);
			elim_c[n] = !r_s1.gone[n] && (r_s1.cnt != '0) && (sum_x <= thr_c[n]);
		end
		r2_c      = r_s1;
		r2_c.gone = r_s1.gone | elim_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= r1_c;
			r_s2 <= r2_c;
		end
	end

	assign vout = v_s2;
	assign rout = r_s2;

endmodule

`default_nettype wire

>>> src/cof_div.sv
// signed sum divided by the live count (0..5), truncating toward zero
// bit-serial long division spread over DIV_ST stages; depends on cof_pkg
`default_nettype none

module cof_div import cof_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   vin,
	input  round_t rin,
	output logic   vout,
	output avg_t   aout
);

	localparam int DIV_ST = 4;
	localparam int BPS    = (SW + DIV_ST - 1) / DIV_ST;
	localparam int WW     = BPS * DIV_ST;

	typedef struct packed {
		logic [NLVL-1:0]         gone;
		logic [NLVL-1:0][LW-1:0] lvl;
		logic                    neg;
		logic [CNT_W-1:0]        cnt;
		logic [CNT_W-1:0]        rem;
		logic [WW-1:0]           work;   // dividend shifts out, quotient shifts in
	} div_t;

	logic v_s [DIV_ST];
	div_t d_s [DIV_ST];
	div_t prep_c;
	div_t nxt_c [DIV_ST];
	logic [SW-1:0] quot_c;

	function automatic div_t div_step(input div_t d);
		div_t           r;
		logic [CNT_W:0] t;
		r = d;
		for (int i = 0; i < BPS; i++) begin
			t = {r.rem, r.work[WW-1]};
			r.work = {r.work[WW-2:0], 1'b0};
			if (t >= {1'b0, r.cnt}) begin
				t = t - {1'b0, r.cnt};
				r.work[0] = 1'b1;
			end
			r.rem = t[CNT_W-1:0];
		end
		return r;
	endfunction

	always_comb begin
		prep_c.gone = rin.gone;
		prep_c.lvl  = rin.lvl;
		prep_c.neg  = rin.sum[SW-1];
		prep_c.cnt  = rin.cnt;
		prep_c.rem  = '0;
		prep_c.work = WW'(rin.sum[SW-1] ? (~rin.sum + SW'(1)) : rin.sum);
		for (int k = 0; k < DIV_ST; k++)
			nxt_c[k] = div_step(k == 0 ? prep_c : d_s[(k == 0) ? 0 : k - 1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_ST; k++)
				v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= vin;
			for (int k = 1; k < DIV_ST; k++)
				v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_ST; k++)
				d_s[k] <= nxt_c[k];
		end
	end

	assign quot_c    = d_s[DIV_ST-1].work[SW-1:0];
	assign vout      = v_s[DIV_ST-1];
	assign aout.gone = d_s[DIV_ST-1].gone;
	assign aout.lvl  = d_s[DIV_ST-1].lvl;
	assign aout.avg  = d_s[DIV_ST-1].neg ? (~quot_c + SW'(1)) : quot_c;

endmodule

`default_nettype wire

>>> src/cof_flow.sv
// neighbour outflows: difference, scaling by the relaxation rate, saturation
// three register stages; depends on cof_pkg
`default_nettype none

module cof_flow import cof_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vin,
	input  avg_t              ain,
	input  logic [RATE_W-1:0] rate,
	output logic              vout,
	output logic [OUT_W-1:0]  flows
);

	localparam int NNB = NLVL - 1;
	localparam int MW  = SW + RATE_W;
	localparam int QW  = MW - FRAC_W;
	localparam logic [QW-1:0] FLOW_MAX = QW'({1'b0, {(VALUE_W-1){1'b1}}});

	logic            v_f1, v_f2, v_f3;
	logic [NNB-1:0]  live_f1, live_f2;
	logic [SW-1:0]   diff_f1 [NNB];
	logic [MW-1:0]   prod_f2 [NNB];
	logic [OUT_W-1:0] flow_f3;
	logic [SW-1:0]   diff_c [NNB];
	logic [QW-1:0]   q_c    [NNB];
	logic [OUT_W-1:0] flow_c;

	// live neighbours sit strictly below the average, so the difference is positive
	always_comb begin
		for (int n = 0; n < NNB; n++)
			diff_c[n] = ain.avg - SW'($signed(ain.lvl[n+1]));
	end

	always_comb begin
		for (int n = 0; n < NNB; n++) begin
			q_c[n] = prod_f2[n][MW-1:FRAC_W];
			if (!live_f2[n])
				flow_c[n*VALUE_W +: VALUE_W] = '0;
			else if (q_c[n] > FLOW_MAX)
				flow_c[n*VALUE_W +: VALUE_W] = FLOW_MAX[VALUE_W-1:0];
			else
				flow_c[n*VALUE_W +: VALUE_W] = q_c[n][VALUE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1 <= 1'b0;
			v_f2 <= 1'b0;
			v_f3 <= 1'b0;
		end else if (en) begin
			v_f1 <= vin;
			v_f2 <= v_f1;
			v_f3 <= v_f2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			live_f1 <= ~ain.gone[NLVL-1:1];
			live_f2 <= live_f1;
			for (int n = 0; n < NNB; n++) begin
				diff_f1[n] <= diff_c[n];
				prod_f2[n] <= MW'(diff_f1[n]) * MW'(rate);
			end
			flow_f3 <= flow_c;
		end
	end

	assign vout  = v_f3;
	assign flows = flow_f3;

endmodule

`default_nettype wire

>>> tb/tb_cell_outflow_minimization.sv
// testbench for cell_outflow_minimization: random and directed cells, checked
// against a behavioral model of the elimination algorithm; depends on cof_pkg
`timescale 1ns / 100ps
`default_nettype none

class flow_scoreboard;
	logic [127:0] flows_pending[$];
	int errors;
	logic [16:0] rate;
	logic [15:0] eps;

	function new();
		errors = 0;
		rate = 17'd32768;
		eps = 16'd66;
	endfunction

	// outflows of one cell by repeated elimination of high levels
	function logic [127:0] cell_flows(logic [319:0] cdat);
		longint lvl[5];
		bit gone[5];
		longint mass, sum, cnt, avg, diff, flow;
		longint r;
		bit changed;
		logic [127:0] res;
		r = (rate > 17'd65536) ? 65536 : longint'(rate);
		mass = longint'($signed(cdat[63:32])) - longint'(eps);
		lvl[0] = longint'($signed(cdat[31:0])) + longint'(eps);
		for (int n = 1; n < 5; n++)
			lvl[n] = longint'($signed(cdat[64*n +: 32]))
				+ longint'($signed(cdat[64*n+32 +: 32]));
		foreach (gone[n]) gone[n] = 0;
		avg = mass;
		changed = 1;
		for (int k = 0; k < 6 && changed; k++) begin
			sum = mass;
			cnt = 0;
			changed = 0;
			for (int n = 0; n < 5; n++) if (!gone[n]) begin
				sum += lvl[n];
				cnt++;
			end
			avg = (cnt != 0) ? sum / cnt : sum;
			for (int n = 0; n < 5; n++) if (!gone[n] && avg <= lvl[n]) begin
				gone[n] = 1;
				changed = 1;
			end
		end
		res = '0;
		for (int n = 1; n < 5; n++) begin
			flow = 0;
			if (!gone[n]) begin
				diff = avg - lvl[n];
				flow = (diff * r) >>> 16;
				if (flow > 64'sd2147483647) flow = 64'sd2147483647;
				if (flow < -64'sd2147483648) flow = -64'sd2147483648;
			end
			res[32*(n-1) +: 32] = flow[31:0];
		end
		return res;
	endfunction

	function void note_cell(logic [319:0] cdat);
		flows_pending.push_back(cell_flows(cdat));
	endfunction

	task report(string msg);
		errors++;
		$display("%s", msg);
	endtask

	task check_flows(logic [127:0] got);
		logic [127:0] want;
		if (flows_pending.size() == 0) begin
			report($sformatf("unexpected result transfer %h", got));
			return;
		end
		want = flows_pending.pop_front();
		for (int f = 0; f < 4; f++)
			if (got[32*f +: 32] !== want[32*f +: 32])
				report($sformatf("flow %0d mismatch: got %h want %h", f,
					got[32*f +: 32], want[32*f +: 32]));
	endtask
endclass

module tb_cell_outflow_minimization;
	import cof_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_we = 0;
	logic [CFG_AW-1:0] cfg_addr = REG_RATE;
	logic [RATE_W-1:0] cfg_wdata = '0;

	flow_scoreboard sb = new();
	bit calm = 0;
	int idle_cycles = 0;

	cell_outflow_minimization dut (.*);

	always #5 clk = ~clk;

	// result side with random stall bursts
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
			if (hold != 0) begin
				m_tready <= 0;
				repeat (hold) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_flows(m_tdata);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [RATE_W-1:0] val);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_RATE) sb.rate = val;
		else sb.eps = val[15:0];
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.flows_pending.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic send_cell(logic [IN_W-1:0] cdat);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= cdat;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_cell(cdat);
	endtask

	function automatic logic [31:0] pick_value(int scale);
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom();
			default: return $signed($urandom_range(0, 2 * scale)) - scale;
		endcase
	endfunction

	function automatic logic [IN_W-1:0] random_cell();
		logic [IN_W-1:0] c;
		int scale;
		scale = 1 << $urandom_range(8, 22);
		for (int i = 0; i < 10; i++)
			c[32*i +: 32] = ($urandom_range(0, 15) == 0) ? $urandom() : pick_value(scale);
		return c;
	endfunction

	initial begin
		logic [IN_W-1:0] c;
		logic [RATE_W-1:0] rates[4] = '{17'd0, 17'd65536, 17'h1FFFF, 17'd12345};
		logic [15:0] epss[4] = '{16'd0, 16'hFFFF, 16'd66, 16'd1000};
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, flat terrain, all eliminated, single low neighbour
		send_cell('0);
		send_cell({10{32'h7FFFFFFF}});
		send_cell({10{32'h80000000}});
		send_cell({{8{32'h80000000}}, 32'h7FFFFFFF, 32'h7FFFFFFF});
		send_cell({{8{32'h7FFFFFFF}}, 32'h80000000, 32'h80000000});
		c = '0;
		c[63:32] = 32'h00100000;
		send_cell(c);
		c[64*3 +: 32] = 32'hFFF00000;
		send_cell(c);
		c = {10{32'h55555555}};
		send_cell(c);
		send_cell(~c);
		for (int ph = 0; ph < 4; ph++) begin
			s_tvalid <= 0;
			drain();
			write_reg(REG_RATE, rates[ph]);
			write_reg(REG_EPS, RATE_W'(epss[ph]));
			for (int i = 0; i < 200; i++) send_cell(random_cell());
		end
		calm = 1;
		for (int i = 0; i < 50; i++) send_cell(random_cell());
		s_tvalid <= 0;
		drain();
		if (sb.errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule

`default_nettype wire
